@@ design/asrd_pkg.sv @@
// ----------------------------------------------------------------------------
// asrd_pkg
// Shared constants, types and the CRC helper for the sector record decoder.
// ----------------------------------------------------------------------------
package asrd_pkg;

    // Data length for the large sector size (the small size is fixed).
    localparam int MAX_SECTOR_BYTES   = 256;
    localparam int SMALL_SECTOR_BYTES = 128;
    localparam int HEADER_BYTES       = 4;

    // Position counter covers header, data and both CRC bytes.
    localparam int POS_W = $clog2(HEADER_BYTES + MAX_SECTOR_BYTES + 2);

    localparam logic [POS_W-1:0] POS_PROTECTION = POS_W'(1);
    localparam logic [POS_W-1:0] POS_TRACK      = POS_W'(2);
    localparam logic [POS_W-1:0] POS_SECTOR     = POS_W'(3);
    localparam logic [POS_W-1:0] POS_DATA_START = POS_W'(HEADER_BYTES);
    localparam logic [POS_W-1:0] POS_END_LARGE  = POS_W'(HEADER_BYTES + MAX_SECTOR_BYTES);
    localparam logic [POS_W-1:0] POS_END_SMALL  = POS_W'(HEADER_BYTES + SMALL_SECTOR_BYTES);

    localparam logic [7:0]  DATA_XOR      = 8'hB3;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY_REFL = 16'h8408;

    localparam logic SIZE_CODE_LARGE = 1'b1;

    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic [7:0] track_number;
        logic [7:0] sector_number;
        logic       crc_mismatch;
        logic       protected_flag;
    } asrd_result_t;

    // Reflected CCITT CRC-16, one byte per call, unrolled into XOR logic.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++)
        begin
            if (crc[0])
                crc = (crc >> 1) ^ CRC_POLY_REFL;
            else
                crc = crc >> 1;
        end
        return crc;
    endfunction

endpackage

@@ design/archive_sector_record_decoder_core.sv @@
// ----------------------------------------------------------------------------
// archive_sector_record_decoder_core
// Walks sector records byte by byte, descrambles data and checks the CRC.
// ----------------------------------------------------------------------------
// Usage:
// Raw record bytes arrive on byte_in with in_valid; a request is taken at a
// clock edge where in_valid is high and in_stall is low. Each record is four
// header bytes, 128 or 256 data bytes (cfg_wr_data: 0 or 1, written with
// cfg_wr_en while idle) and two CRC bytes, high byte first.
// Each data byte yields one data result, registered into the output register
// (or the skid entry while it is occupied); the second CRC byte yields one
// summary result (track, sector, CRC mismatch, protection flag) the same way.
// Header bytes and the first CRC byte give no result. The block takes one byte
// per cycle while in_stall is low; the byte-wide CRC update is combinational.
// Results sit in an output register backed by one skid entry, so a new byte
// is still taken while a result waits. in_stall rises only when both are
// full, and drops once out_stall is released.
// Reset puts the block at the start of a record with the CRC at FFFF and
// selects the 256-byte sector size; any pending result is dropped.
// ----------------------------------------------------------------------------
module archive_sector_record_decoder_core
    import asrd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] byte_in,

    output logic       out_valid,
    input  logic       out_stall,
    output logic       kind,
    output logic [7:0] data_byte,
    output logic [7:0] byte_index,
    output logic [7:0] track_number,
    output logic [7:0] sector_number,
    output logic       crc_mismatch,
    output logic       protected_flag
);

    logic              size_code_reg;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [15:0]       crc_reg, crc_next;
    logic [7:0]        prot_reg, prot_next;
    logic [7:0]        track_reg, track_next;
    logic [7:0]        sector_reg, sector_next;
    logic [7:0]        crc_hi_reg, crc_hi_next;

    logic              out_valid_reg, out_valid_next;
    asrd_result_t      out_reg, out_next;
    logic              skid_valid_reg, skid_valid_next;
    asrd_result_t      skid_reg, skid_next;

    logic              accept;
    logic              out_take;
    logic              res_valid;
    asrd_result_t      res;
    logic [POS_W-1:0]  data_end;
    logic [POS_W-1:0]  data_offset;
    logic [7:0]        decoded;

    assign accept      = in_valid && !in_stall;
    assign out_take    = out_valid_reg && !out_stall;
    assign data_end    = (size_code_reg == SIZE_CODE_LARGE) ? POS_END_LARGE : POS_END_SMALL;
    assign data_offset = pos_reg - POS_DATA_START;
    assign decoded     = byte_in ^ DATA_XOR;

    // Record walk and the result for the byte being taken.
    always_comb
    begin
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        prot_next   = prot_reg;
        track_next  = track_reg;
        sector_next = sector_reg;
        crc_hi_next = crc_hi_reg;
        res_valid   = 1'b0;
        res         = '0;

        if (accept)
        begin
            if (pos_reg < POS_DATA_START)
            begin
                if (pos_reg == POS_PROTECTION)
                    prot_next = byte_in;
                if (pos_reg == POS_TRACK)
                    track_next = byte_in;
                if (pos_reg == POS_SECTOR)
                    sector_next = byte_in;
                crc_next = crc_feed(crc_reg, byte_in);
                pos_next = pos_reg + POS_W'(1);
            end
            else if (pos_reg < data_end)
            begin
                crc_next       = crc_feed(crc_reg, decoded);
                pos_next       = pos_reg + POS_W'(1);
                res_valid      = 1'b1;
                res.kind       = KIND_DATA;
                res.data_byte  = decoded;
                res.byte_index = data_offset[7:0];
            end
            else if (pos_reg == data_end)
            begin
                crc_hi_next = byte_in;
                pos_next    = pos_reg + POS_W'(1);
            end
            else
            begin
                // Anything past the first CRC byte closes the record, which
                // also covers a size change in the middle of a record.
                res_valid          = 1'b1;
                res.kind           = KIND_SUMMARY;
                res.track_number   = track_reg;
                res.sector_number  = sector_reg;
                res.crc_mismatch   = ({crc_hi_reg, byte_in} != crc_reg);
                res.protected_flag = (prot_reg != 8'h00);
                pos_next           = '0;
                crc_next           = CRC_INIT;
            end
        end
    end

    // Output register with one skid entry behind it.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;

        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || out_take)
        begin
            out_valid_next = res_valid;
            out_next       = res;
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_code_reg  <= SIZE_CODE_LARGE;
            pos_reg        <= '0;
            crc_reg        <= CRC_INIT;
            prot_reg       <= '0;
            track_reg      <= '0;
            sector_reg     <= '0;
            crc_hi_reg     <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                size_code_reg <= cfg_wr_data;
            pos_reg        <= pos_next;
            crc_reg        <= crc_next;
            prot_reg       <= prot_next;
            track_reg      <= track_next;
            sector_reg     <= sector_next;
            crc_hi_reg     <= crc_hi_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign in_stall       = skid_valid_reg;
    assign out_valid      = out_valid_reg;
    assign kind           = out_reg.kind;
    assign data_byte      = out_reg.data_byte;
    assign byte_index     = out_reg.byte_index;
    assign track_number   = out_reg.track_number;
    assign sector_number  = out_reg.sector_number;
    assign crc_mismatch   = out_reg.crc_mismatch;
    assign protected_flag = out_reg.protected_flag;

endmodule
